// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file of the HSV to gamma RGB converter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clk edge outside reset.
`define HSVG_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Condition that must never be true.
`define HSVG_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

`endif

// ===== rtl/hsvg_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the HSV to gamma RGB converter.
package hsvg_pkg;

	localparam int unsigned HUE_W = 13;
	localparam int unsigned FRAC_W = 9;
	localparam int unsigned LVL_W = 8;
	localparam int unsigned GAMMA_DEPTH = 256;
	localparam int unsigned GAMMA_AW = 8;
	localparam int unsigned SPAN = 960;
	localparam int unsigned QUEUE_DEPTH_DEF = 4;

	localparam logic [HUE_W-1:0] HUE_MAX = 13'd5759;
	localparam logic [FRAC_W-1:0] UNIT_ONE = 9'd256;

	typedef logic op_t;
	localparam op_t OP_CONVERT = 1'b0;
	localparam op_t OP_TABLE = 1'b1;

	typedef logic [2:0] sector_t;
	localparam sector_t SEC_RY = 3'd0;
	localparam sector_t SEC_YG = 3'd1;
	localparam sector_t SEC_GC = 3'd2;
	localparam sector_t SEC_CB = 3'd3;
	localparam sector_t SEC_BM = 3'd4;
	localparam sector_t SEC_MR = 3'd5;

	typedef struct packed {
		op_t op;
		sector_t sector;
		logic [9:0] wgt;
		logic [16:0] chroma;
		logic [FRAC_W-1:0] val;
		logic [GAMMA_AW-1:0] idx;
		logic [LVL_W-1:0] entry;
	} item_t;

endpackage

// ===== rtl/hsvg_ram.sv =====
`timescale 1ns / 1ps
// Generic single write port, single read port RAM with registered read.
module hsvg_ram #(
	parameter int unsigned WIDTH = hsvg_pkg::LVL_W,
	parameter int unsigned DEPTH = hsvg_pkg::GAMMA_DEPTH
) (
	input logic clk,
	input logic wr_en,
	input logic [$clog2(DEPTH)-1:0] wr_addr,
	input logic [WIDTH-1:0] wr_data,
	input logic rd_en,
	input logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== rtl/hsvg_front.sv =====
`timescale 1ns / 1ps
// Front stage: accepts transactions, saturates inputs, finds sector, weight and chroma.
module hsvg_front (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input logic opcode,
	input logic [12:0] hue,
	input logic [8:0] saturation,
	input logic [8:0] brightness,
	input logic [7:0] table_index,
	input logic [7:0] table_entry,
	input logic q_full,
	output logic q_push,
	output hsvg_pkg::item_t item_s1
);
	import hsvg_pkg::*;

	logic valid_s1;
	logic [HUE_W-1:0] hue_c;
	logic [FRAC_W-1:0] sat_c;
	logic [FRAC_W-1:0] val_c;
	sector_t sector;
	logic [HUE_W-1:0] base;
	logic [HUE_W-1:0] t13;
	logic [10:0] t;
	logic [10:0] w11;
	logic [17:0] cprod;
	item_t item_d;

	assign full = valid_s1 && q_full;
	assign q_push = valid_s1 && !q_full;

	assign hue_c = (hue > HUE_MAX) ? HUE_MAX : hue;
	assign sat_c = (saturation > UNIT_ONE) ? UNIT_ONE : saturation;
	assign val_c = (brightness > UNIT_ONE) ? UNIT_ONE : brightness;

	always_comb begin
		if (hue_c < 13'(SPAN)) begin
			sector = SEC_RY;
		end else if (hue_c < 13'(2 * SPAN)) begin
			sector = SEC_YG;
		end else if (hue_c < 13'(3 * SPAN)) begin
			sector = SEC_GC;
		end else if (hue_c < 13'(4 * SPAN)) begin
			sector = SEC_CB;
		end else if (hue_c < 13'(5 * SPAN)) begin
			sector = SEC_BM;
		end else begin
			sector = SEC_MR;
		end
	end

	always_comb begin
		case (sector) inside
			SEC_RY, SEC_YG: base = '0;
			SEC_GC, SEC_CB: base = 13'(2 * SPAN);
			default: base = 13'(4 * SPAN);
		endcase
	end

	assign t13 = hue_c - base;
	assign t = t13[10:0];
	// weight of the secondary component: rises over even sectors, falls over odd ones
	assign w11 = (t >= 11'(SPAN)) ? (11'(2 * SPAN) - t) : t;
	assign cprod = val_c * sat_c;

	always_comb begin
		item_d.op = opcode;
		item_d.sector = sector;
		item_d.wgt = w11[9:0];
		item_d.chroma = cprod[16:0];
		item_d.val = val_c;
		item_d.idx = table_index;
		item_d.entry = table_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!full) begin
			valid_s1 <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (push && !full) begin
			item_s1 <= item_d;
		end
	end

endmodule

// ===== rtl/hsvg_queue.sv =====
`timescale 1ns / 1ps
// Small register FIFO between the front and back stages.
module hsvg_queue #(
	parameter int unsigned DEPTH = hsvg_pkg::QUEUE_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic q_push,
	input hsvg_pkg::item_t wr_item,
	output logic q_full,
	input logic q_pop,
	output logic q_valid,
	output hsvg_pkg::item_t rd_item
);
	import hsvg_pkg::*;

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	item_t mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign q_full = (count_q == CW'(DEPTH));
	assign q_valid = (count_q != '0);
	assign rd_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (q_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (q_push && !q_pop) begin
				count_q <= count_q + 1'b1;
			end else if (q_pop && !q_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_push) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

endmodule

// ===== rtl/hsvg_back.sv =====
`timescale 1ns / 1ps
// Back stages: channel levels, gamma table writes and lookups, result register.
module hsvg_back (
	input logic clk,
	input logic arst_n,
	input logic q_valid,
	input hsvg_pkg::item_t q_item,
	output logic q_pop,
	output logic empty,
	input logic pop,
	output logic [7:0] red,
	output logic [7:0] green,
	output logic [7:0] blue
);
	import hsvg_pkg::*;

	logic adv;
	logic valid_s2;
	logic valid_s3;
	op_t op_s2;
	sector_t sector_s2;
	logic [GAMMA_AW-1:0] idx_s2;
	logic [LVL_W-1:0] entry_s2;
	logic [25:0] cw_s2;
	logic [25:0] m960_s2;
	logic [LVL_W-1:0] ml_s2;
	logic [LVL_W-1:0] mx_s2;

	logic [16:0] m_d;
	logic [26:0] cw_p;
	logic [26:0] m960_p;
	logic [24:0] ml_p;
	logic [16:0] mx_p;

	logic [25:0] n_sum;
	logic [29:0] x_p;
	logic [LVL_W-1:0] xl;
	logic [GAMMA_AW-1:0] r_addr;
	logic [GAMMA_AW-1:0] g_addr;
	logic [GAMMA_AW-1:0] b_addr;
	logic wr_en;

	assign adv = !valid_s3 || pop;
	assign q_pop = adv && q_valid;
	assign empty = !valid_s3;

	// numerators over 65536*960; 255/(65536*960) = 17/2^22
	assign m_d = {q_item.val, 8'd0} - q_item.chroma;
	assign cw_p = q_item.chroma * q_item.wgt;
	assign m960_p = m_d * 27'(SPAN);
	assign ml_p = m_d * 25'd255;
	assign mx_p = q_item.val * 17'd255;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= q_valid;
			valid_s3 <= valid_s2 && (op_s2 == OP_CONVERT);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s2 <= q_item.op;
			sector_s2 <= q_item.sector;
			idx_s2 <= q_item.idx;
			entry_s2 <= q_item.entry;
			cw_s2 <= cw_p[25:0];
			m960_s2 <= m960_p[25:0];
			ml_s2 <= ml_p[23:16];
			mx_s2 <= mx_p[15:8];
		end
	end

	assign n_sum = cw_s2 + m960_s2;
	assign x_p = 30'(n_sum) * 30'd17;
	assign xl = x_p[29:22];

	always_comb begin
		case (sector_s2)
			SEC_RY: begin
				r_addr = mx_s2; g_addr = xl; b_addr = ml_s2;
			end
			SEC_YG: begin
				r_addr = xl; g_addr = mx_s2; b_addr = ml_s2;
			end
			SEC_GC: begin
				r_addr = ml_s2; g_addr = mx_s2; b_addr = xl;
			end
			SEC_CB: begin
				r_addr = ml_s2; g_addr = xl; b_addr = mx_s2;
			end
			SEC_BM: begin
				r_addr = xl; g_addr = ml_s2; b_addr = mx_s2;
			end
			default: begin
				r_addr = mx_s2; g_addr = ml_s2; b_addr = xl;
			end
		endcase
	end

	assign wr_en = adv && valid_s2 && (op_s2 == OP_TABLE);

	hsvg_ram #(.WIDTH(LVL_W), .DEPTH(GAMMA_DEPTH)) u_ram_r (
		.clk(clk), .wr_en(wr_en), .wr_addr(idx_s2), .wr_data(entry_s2),
		.rd_en(adv), .rd_addr(r_addr), .rd_data(red)
	);

	hsvg_ram #(.WIDTH(LVL_W), .DEPTH(GAMMA_DEPTH)) u_ram_g (
		.clk(clk), .wr_en(wr_en), .wr_addr(idx_s2), .wr_data(entry_s2),
		.rd_en(adv), .rd_addr(g_addr), .rd_data(green)
	);

	hsvg_ram #(.WIDTH(LVL_W), .DEPTH(GAMMA_DEPTH)) u_ram_b (
		.clk(clk), .wr_en(wr_en), .wr_addr(idx_s2), .wr_data(entry_s2),
		.rd_en(adv), .rd_addr(b_addr), .rd_data(blue)
	);

endmodule

// ===== rtl/hsv_to_rgb_gamma.sv =====
`timescale 1ns / 1ps
// Top level of the HSV to gamma-corrected RGB converter.
// Takes one transaction per clock while full is low, and delivers one result per
// clock while pop is held. A conversion (opcode 0) reaches red/green/blue through
// four registers: the front register that holds the saturated inputs, the sector and
// chroma, the FIFO of QUEUE_DEPTH entries, the channel products, and the registered
// read of the gamma table. A table write (opcode 1) follows the same path and
// yields no result, so it is ordered with the conversions around it. The gamma table
// is kept as three identical 256 x 8 RAMs, one read port per channel; entries must
// be written before a conversion reads them. Rate is one transaction per cycle, set
// by the back pipeline, which advances whenever the result register is free or
// being popped.
`include "assert_macros.svh"
module hsv_to_rgb_gamma #(
	parameter int unsigned QUEUE_DEPTH = hsvg_pkg::QUEUE_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input logic opcode,
	input logic [12:0] hue,
	input logic [8:0] saturation,
	input logic [8:0] brightness,
	input logic [7:0] table_index,
	input logic [7:0] table_entry,
	output logic empty,
	input logic pop,
	output logic [7:0] red,
	output logic [7:0] green,
	output logic [7:0] blue
);
	import hsvg_pkg::*;

	logic q_push;
	logic q_full;
	logic q_pop;
	logic q_valid;
	item_t f_item;
	item_t q_item;

	hsvg_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.opcode(opcode), .hue(hue), .saturation(saturation), .brightness(brightness),
		.table_index(table_index), .table_entry(table_entry),
		.q_full(q_full), .q_push(q_push), .item_s1(f_item)
	);

	hsvg_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk(clk), .arst_n(arst_n), .q_push(q_push), .wr_item(f_item), .q_full(q_full),
		.q_pop(q_pop), .q_valid(q_valid), .rd_item(q_item)
	);

	hsvg_back u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
		.empty(empty), .pop(pop), .red(red), .green(green), .blue(blue)
	);

	`HSVG_NEVER(a_push_full, q_push && q_full, "front pushed into a full queue")
	`HSVG_ASSERT(a_push_lands, q_push && !q_valid |=> q_valid, "push into empty queue lost")
	`HSVG_ASSERT(a_pop_valid, q_pop |-> q_valid, "back popped an empty queue")

endmodule

// ===== dv/tb_hsv_to_rgb_gamma.sv =====
`timescale 1ns / 1ps
// Testbench for the HSV to gamma RGB converter with directed and random transactions.
module tb_hsv_to_rgb_gamma;
	import hsvg_pkg::*;

	localparam longint unsigned LEVEL_DEN = 64'd62914560;
	localparam int RANDOM_ITEMS = 824;

	typedef struct {
		op_t op;
		logic [12:0] hue;
		logic [8:0] sat;
		logic [8:0] val;
		logic [7:0] idx;
		logic [7:0] entry;
		bit drain;
	} pix_txn_t;

	typedef struct {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} rgb_lvl_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic opcode = OP_CONVERT;
	logic [12:0] hue = '0;
	logic [8:0] saturation = '0;
	logic [8:0] brightness = '0;
	logic [7:0] table_index = '0;
	logic [7:0] table_entry = '0;
	logic pop = 1'b0;
	logic full;
	logic empty;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;

	pix_txn_t pending[$];
	rgb_lvl_t rgb_expected[$];
	logic [7:0] gamma_shadow[256];
	int n_accepted = 0;
	int n_total = 1;
	int errors = 0;

	hsv_to_rgb_gamma i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.opcode(opcode),
		.hue(hue),
		.saturation(saturation),
		.brightness(brightness),
		.table_index(table_index),
		.table_entry(table_entry),
		.empty(empty),
		.pop(pop),
		.red(red),
		.green(green),
		.blue(blue)
	);

	always #5 clk = ~clk;

	task automatic report_mismatch(string what, int got, int want);
		errors++;
		if (errors <= 100)
			$display("%0t: %s: got %0d expected %0d", $realtime, what, got, want);
	endtask

	function automatic logic [7:0] chan_level(longint unsigned num);
		longint unsigned lv;
		lv = (255 * num) / LEVEL_DEN;
		if (lv > 255)
			lv = 255;
		return gamma_shadow[lv[7:0]];
	endfunction

	function automatic rgb_lvl_t predict_rgb(pix_txn_t tr);
		int unsigned h, s, v, t, span_off;
		longint unsigned c, cn, xn, mn, r, g, b;
		rgb_lvl_t res;
		h = tr.hue;
		s = tr.sat;
		v = tr.val;
		if (h > HUE_MAX)
			h = HUE_MAX;
		if (s > UNIT_ONE)
			s = UNIT_ONE;
		if (v > UNIT_ONE)
			v = UNIT_ONE;
		c = v * s;
		t = h % (2 * SPAN);
		span_off = (t >= SPAN) ? t - SPAN : SPAN - t;
		cn = c * SPAN;
		xn = c * (SPAN - span_off);
		mn = (longint'(v) * UNIT_ONE - c) * SPAN;
		r = 0;
		g = 0;
		b = 0;
		case (sector_t'(h / SPAN))
			SEC_RY: begin r = cn; g = xn; end
			SEC_YG: begin r = xn; g = cn; end
			SEC_GC: begin g = cn; b = xn; end
			SEC_CB: begin g = xn; b = cn; end
			SEC_BM: begin r = xn; b = cn; end
			default: begin r = cn; b = xn; end
		endcase
		res.r = chan_level(r + mn);
		res.g = chan_level(g + mn);
		res.b = chan_level(b + mn);
		return res;
	endfunction

	function automatic pix_txn_t mk_conv(int h, int s, int v);
		pix_txn_t tr;
		tr.op = OP_CONVERT;
		tr.hue = 13'(h);
		tr.sat = 9'(s);
		tr.val = 9'(v);
		tr.idx = 8'($urandom);
		tr.entry = 8'($urandom);
		tr.drain = 1'b0;
		return tr;
	endfunction

	function automatic pix_txn_t mk_write(int i, int e);
		pix_txn_t tr;
		tr.op = OP_TABLE;
		tr.hue = 13'($urandom);
		tr.sat = 9'($urandom);
		tr.val = 9'($urandom);
		tr.idx = 8'(i);
		tr.entry = 8'(e);
		tr.drain = 1'b0;
		return tr;
	endfunction

	function automatic int rand_frac();
		int unsigned k;
		k = $urandom_range(0, 99);
		if (k < 8)
			return 0;
		if (k < 16)
			return 256;
		if (k < 24)
			return $urandom_range(257, 511);
		return $urandom_range(0, 256);
	endfunction

	function automatic int rand_hue();
		int unsigned k;
		k = $urandom_range(0, 99);
		if (k < 10)
			return $urandom_range(5760, 8191);
		if (k < 22)
			return $urandom_range(1, 6) * SPAN - 1 + $urandom_range(0, 2);
		return $urandom_range(0, 5759);
	endfunction

	// sender idles 19% then 46% then never; receiver the other way round
	function automatic int tx_idle_pct();
		case (n_accepted * 3 / n_total)
			0: return 19;
			1: return 46;
			default: return 0;
		endcase
	endfunction

	function automatic int rx_idle_pct();
		case (n_accepted * 3 / n_total)
			0: return 46;
			1: return 19;
			default: return 0;
		endcase
	endfunction

	// driver
	always @(posedge clk) begin
		pix_txn_t acc;
		pix_txn_t nxt;
		bit go;
		if (arst_n) begin
			if (push && !full) begin
				acc = pending.pop_front();
				if (acc.op == OP_TABLE)
					gamma_shadow[acc.idx] = acc.entry;
				else
					rgb_expected.push_back(predict_rgb(acc));
				n_accepted++;
			end
			go = 1'b0;
			if (pending.size() != 0) begin
				if (push && full)
					go = 1'b1;
				else if (pending[0].drain) begin
					if (rgb_expected.size() == 0) begin
						pending[0].drain = 1'b0;
						go = 1'b1;
					end
				end else
					go = ($urandom_range(0, 99) >= tx_idle_pct());
			end
			if (go) begin
				nxt = pending[0];
				push <= 1'b1;
				opcode <= nxt.op;
				hue <= nxt.hue;
				saturation <= nxt.sat;
				brightness <= nxt.val;
				table_index <= nxt.idx;
				table_entry <= nxt.entry;
			end else
				push <= 1'b0;
		end
	end

	// monitor
	always @(posedge clk) begin
		rgb_lvl_t want;
		if (arst_n) begin
			if (pop && !empty) begin
				if (rgb_expected.size() == 0)
					report_mismatch("unexpected result, red", red, 0);
				else begin
					want = rgb_expected.pop_front();
					if (red !== want.r)
						report_mismatch("red", red, want.r);
					if (green !== want.g)
						report_mismatch("green", green, want.g);
					if (blue !== want.b)
						report_mismatch("blue", blue, want.b);
				end
			end
			pop <= ($urandom_range(0, 99) >= rx_idle_pct());
		end
	end

	initial begin
		pix_txn_t tr;
		// identity table so the directed conversions show raw levels
		for (int i = 0; i < 256; i++)
			pending.push_back(mk_write(i, i));

		pending.push_back(mk_conv(0, 256, 256));
		pending.push_back(mk_conv(959, 256, 256));
		pending.push_back(mk_conv(960, 256, 256));
		pending.push_back(mk_conv(1919, 256, 256));
		pending.push_back(mk_conv(1920, 256, 256));
		pending.push_back(mk_conv(2880, 256, 256));
		pending.push_back(mk_conv(3840, 256, 256));
		pending.push_back(mk_conv(4800, 256, 256));
		pending.push_back(mk_conv(5759, 256, 256));
		pending.push_back(mk_conv(5760, 256, 256));
		pending.push_back(mk_conv(8191, 511, 511));
		pending.push_back(mk_conv(1000, 0, 256));
		pending.push_back(mk_conv(3000, 256, 0));
		pending.push_back(mk_conv(2000, 511, 128));
		pending.push_back(mk_conv(4000, 128, 511));
		pending.push_back(mk_write(255, 0));
		tr = mk_conv(0, 256, 256);
		tr.drain = 1'b1;
		pending.push_back(tr);
		pending.push_back(mk_write(0, 255));
		pending.push_back(mk_conv(0, 0, 0));
		pending.push_back(mk_conv(480, 100, 200));

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if ($urandom_range(0, 99) < 15)
				tr = mk_write($urandom_range(0, 255), $urandom_range(0, 255));
			else
				tr = mk_conv(rand_hue(), rand_frac(), rand_frac());
			tr.drain = (i % 250 == 0);
			pending.push_back(tr);
		end
		n_total = pending.size();

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		while (pending.size() != 0)
			@(posedge clk);
		while (rgb_expected.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
